>>> design/led_cosine_fade_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// LED cosine fade engine assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LED_COSINE_FADE_ENGINE_UNIT_MACROS_SVH
`define LED_COSINE_FADE_ENGINE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LCFE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcfe assertion failed");
`define LCFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcfe assertion failed");
`else
`define LCFE_ASSERT_IMPL(label, ante, cons)
`define LCFE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/lcfe_pkg.sv
// ----------------------------------------------------------------------------
// LED cosine fade engine package
// Shared constants, types and the ease and PWM scaling tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcfe_pkg;

    localparam int FADE_STEPS = 64;
    localparam int PWM_BITS   = 10;

    localparam int IDX_W  = $clog2(FADE_STEPS);
    localparam int EASE_W = 17;
    localparam int DUTY_W = 8;
    localparam int PWM_W  = 10;
    localparam int CFG_IDX_W = 2;

    localparam longint unsigned PWM_MAX = (64'd1 << PWM_BITS) - 64'd1;

    localparam int CMD_DEPTH = 2;
    localparam int CQ_AW     = $clog2(CMD_DEPTH);
    localparam int CQ_CW     = CQ_AW + 1;
    localparam int RES_DEPTH = 4;
    localparam int RQ_AW     = $clog2(RES_DEPTH);
    localparam int RQ_CW     = RQ_AW + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CONNECTED_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECTED_LEVEL = 2'd1;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint          ONE_Q30 = 64'sd1073741824;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FADING,
        PH_FINISHING
    } phase_t;

    typedef enum logic [1:0] {
        B_WAIT,
        B_MUL,
        B_OUT
    } back_state_t;

    typedef enum logic {
        CMD_TICK,
        CMD_NOTIFY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [DUTY_W-1:0] target;
    } cmd_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [PWM_W-1:0]  pwm_duty;
        logic              last;
    } res_t;

    typedef logic [EASE_W-1:0] ease_rom_t [FADE_STEPS];
    typedef logic [PWM_W-1:0]  pwm_rom_t [256];

    function automatic logic [EASE_W-1:0] ease_value(input int unsigned i);
        longint unsigned a;
        longint unsigned b;
        longint unsigned b2;
        longint unsigned term;
        longint          c;
        longint          e;
        logic            second;
        a      = (PI_Q30 * longint'(i)) / (FADE_STEPS - 1);
        second = (64'd2 * a) > PI_Q30;
        b      = second ? (PI_Q30 - a) : a;
        b2     = (b * b) >> 30;
        term   = 64'd1073741824;
        c      = ONE_Q30;
        term = ((term * b2) >> 30) / 2;   c = c - longint'(term);
        term = ((term * b2) >> 30) / 12;  c = c + longint'(term);
        term = ((term * b2) >> 30) / 30;  c = c - longint'(term);
        term = ((term * b2) >> 30) / 56;  c = c + longint'(term);
        term = ((term * b2) >> 30) / 90;  c = c - longint'(term);
        term = ((term * b2) >> 30) / 132; c = c + longint'(term);
        term = ((term * b2) >> 30) / 182; c = c - longint'(term);
        term = ((term * b2) >> 30) / 240; c = c + longint'(term);
        term = ((term * b2) >> 30) / 306; c = c - longint'(term);
        if (c < 0)
        begin
            c = 0;
        end
        if (c > ONE_Q30)
        begin
            c = ONE_Q30;
        end
        e = second ? (ONE_Q30 + c) / 2 : (ONE_Q30 - c) / 2;
        return EASE_W'((e + 64'sd8192) >>> 14);
    endfunction

    function automatic ease_rom_t build_ease();
        ease_rom_t rom;
        for (int i = 0; i < FADE_STEPS; i++)
        begin
            rom[i] = ease_value(i);
        end
        return rom;
    endfunction

    function automatic pwm_rom_t build_pwm();
        pwm_rom_t        rom;
        longint unsigned v;
        for (int d = 0; d < 256; d++)
        begin
            v      = (longint'(d) * PWM_MAX) / 255;
            rom[d] = PWM_W'(v);
        end
        return rom;
    endfunction

    localparam ease_rom_t EASE_ROM = build_ease();
    localparam pwm_rom_t  PWM_ROM  = build_pwm();

endpackage

>>> design/lcfe_front.sv
// ----------------------------------------------------------------------------
// LED cosine fade engine front end
// Holds the level registers and link tracking, drops repeated link events and
// queues ticks and notifications for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcfe_front
    import lcfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 action,
    input  logic                 connected,
    output logic                 full,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUTY_W-1:0]    cfg_data,
    output logic                 cmd_valid,
    output cmd_t                 cmd,
    input  logic                 cmd_pop
);

    logic [DUTY_W-1:0] conn_level_reg;
    logic [DUTY_W-1:0] disc_level_reg;
    logic              link_state_reg;
    logic              link_known_reg;
    cmd_t              cmd_mem_reg [CMD_DEPTH];
    logic [CQ_AW-1:0]  wr_ptr_reg;
    logic [CQ_AW-1:0]  rd_ptr_reg;
    logic [CQ_CW-1:0]  count_reg;
    logic [CQ_CW-1:0]  count_next;

    logic accept;
    logic ignore;
    logic enq;
    logic deq;
    cmd_t new_cmd;

    assign cfg_ready = 1'b1;
    assign full      = (count_reg == CQ_CW'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = cmd_mem_reg[rd_ptr_reg];

    always_comb
    begin
        accept = push && !full;
        ignore = action && link_known_reg && (connected == link_state_reg);
        enq    = accept && !ignore;
        deq    = cmd_pop && cmd_valid;
        if (action)
        begin
            new_cmd.kind   = CMD_NOTIFY;
            new_cmd.target = connected ? conn_level_reg : disc_level_reg;
        end
        else
        begin
            new_cmd.kind   = CMD_TICK;
            new_cmd.target = '0;
        end
        count_next = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + CQ_CW'(1);
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - CQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_level_reg <= 8'd255;
            disc_level_reg <= 8'd0;
            link_state_reg <= 1'b0;
            link_known_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CONNECTED_LEVEL:    conn_level_reg <= cfg_data;
                    CFG_DISCONNECTED_LEVEL: disc_level_reg <= cfg_data;
                    default:                ;
                endcase
            end
            if (enq && action)
            begin
                link_known_reg <= 1'b1;
                link_state_reg <= connected;
            end
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + CQ_AW'(1);
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + CQ_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            cmd_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> design/lcfe_back.sv
// ----------------------------------------------------------------------------
// LED cosine fade engine back end
// Runs the fade sequencer: one tick or notification at a time, with the ease
// multiply in its own cycle before the duty is formed and queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "led_cosine_fade_engine_unit_macros.svh"

module lcfe_back
    import lcfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_pop,
    output logic             res_push,
    output res_t             res,
    input  logic [RQ_CW-1:0] res_count
);

    back_state_t       state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic              notify_reg, notify_next;
    logic [DUTY_W-1:0] pending_reg, pending_next;
    logic [DUTY_W-1:0] present_reg, present_next;
    logic [DUTY_W-1:0] start_reg, start_next;
    logic [DUTY_W-1:0] target_reg, target_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic signed [26:0] prod_reg, prod_next;

    logic               room;
    logic               begin_fade;
    logic [DUTY_W-1:0]  begin_from;
    logic signed [8:0]  diff_w;
    logic signed [17:0] ease_w;
    logic signed [26:0] sum_w;
    logic [DUTY_W-1:0]  duty_w;

    always_comb
    begin
        diff_w = $signed({1'b0, target_reg}) - $signed({1'b0, start_reg});
        ease_w = $signed({1'b0, EASE_ROM[idx_reg]});
        sum_w  = $signed({3'b000, start_reg, 16'h0000}) + prod_reg;
        duty_w = sum_w[23:16];
        room   = (res_count <= RQ_CW'(RES_DEPTH - 2));
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        notify_next  = notify_reg;
        pending_next = pending_reg;
        present_next = present_reg;
        start_next   = start_reg;
        target_next  = target_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        prod_next    = prod_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res          = '0;
        begin_fade   = 1'b0;
        begin_from   = present_reg;
        case (state_reg)
            B_WAIT:
            begin
                if (cmd_valid && room)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_NOTIFY:
                        begin
                            notify_next  = 1'b1;
                            pending_next = cmd.target;
                        end
                        default:
                        begin
                            case (phase_reg)
                                PH_FADING:
                                begin
                                    if (notify_reg)
                                    begin
                                        begin_fade = 1'b1;
                                    end
                                    else
                                    begin
                                        idx_next   = step_reg;
                                        state_next = B_MUL;
                                        if (step_reg == IDX_W'(FADE_STEPS - 1))
                                        begin
                                            phase_next = PH_FINISHING;
                                        end
                                        else
                                        begin
                                            step_next = step_reg + IDX_W'(1);
                                        end
                                    end
                                end
                                PH_FINISHING:
                                begin
                                    res_push     = 1'b1;
                                    res.duty     = target_reg;
                                    res.pwm_duty = PWM_ROM[target_reg];
                                    res.last     = !notify_reg;
                                    present_next = target_reg;
                                    begin_from   = target_reg;
                                    if (notify_reg)
                                    begin
                                        begin_fade = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_IDLE;
                                    end
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                    if (notify_reg)
                                    begin
                                        begin_fade = 1'b1;
                                    end
                                end
                            endcase
                        end
                    endcase
                end
                if (begin_fade)
                begin
                    notify_next = 1'b0;
                    target_next = pending_reg;
                    start_next  = begin_from;
                    idx_next    = '0;
                    step_next   = IDX_W'(1);
                    phase_next  = PH_FADING;
                    state_next  = B_MUL;
                end
            end
            B_MUL:
            begin
                prod_next  = diff_w * ease_w;
                state_next = B_OUT;
            end
            B_OUT:
            begin
                res_push     = 1'b1;
                res.duty     = duty_w;
                res.pwm_duty = PWM_ROM[duty_w];
                res.last     = 1'b1;
                present_next = duty_w;
                state_next   = B_WAIT;
            end
            default:
            begin
                state_next = B_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_WAIT;
            phase_reg   <= PH_IDLE;
            notify_reg  <= 1'b0;
            pending_reg <= '0;
            present_reg <= '0;
            start_reg   <= '0;
            target_reg  <= '0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            notify_reg  <= notify_next;
            pending_reg <= pending_next;
            present_reg <= present_next;
            start_reg   <= start_next;
            target_reg  <= target_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        prod_reg <= prod_next;
    end

    `LCFE_ASSERT_NEXT(a_mul_then_out, state_reg == B_MUL, state_reg == B_OUT)
    `LCFE_ASSERT_IMPL(a_res_room, res_push, res_count < RQ_CW'(RES_DEPTH))
    `LCFE_ASSERT_IMPL(a_sum_range, state_reg == B_OUT, sum_w[26:24] == 3'b000)

endmodule

>>> design/lcfe_res_queue.sv
// ----------------------------------------------------------------------------
// LED cosine fade engine result queue
// Small first-in first-out buffer that holds results until they are popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcfe_res_queue
    import lcfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  res_t             wr_data,
    input  logic             pop,
    output logic             empty,
    output res_t             rd_data,
    output logic [RQ_CW-1:0] count
);

    res_t             mem_reg [RES_DEPTH];
    logic [RQ_AW-1:0] wr_ptr_reg;
    logic [RQ_AW-1:0] rd_ptr_reg;
    logic [RQ_CW-1:0] count_reg;
    logic [RQ_CW-1:0] count_next;
    logic             deq;

    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

    always_comb
    begin
        deq        = pop && !empty;
        count_next = count_reg;
        if (wr_en && !deq)
        begin
            count_next = count_reg + RQ_CW'(1);
        end
        else if (deq && !wr_en)
        begin
            count_next = count_reg - RQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + RQ_AW'(1);
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + RQ_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> design/led_cosine_fade_engine_unit.sv
// A fade-step tick is popped from the command queue, multiplied in B_MUL and formed into a
// duty in B_OUT, which writes it to the result queue. A final-step tick writes its first beat
// as it is popped, and a pending link event then sends step 0 of a new fade through B_MUL and
// B_OUT. Link events are only recorded when popped; the sequencer waits while fewer than two
// result slots are free. Pushes are taken each cycle until the 2-entry command queue fills.
// Reset is asynchronous and returns all control, level and fade state to idle.
// ----------------------------------------------------------------------------
// LED cosine fade engine top level
// Raised-cosine LED brightness fade driven by ticks and link events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_cosine_fade_engine_unit
    import lcfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 action,
    input  logic                 connected,
    output logic                 empty,
    input  logic                 pop,
    output logic [DUTY_W-1:0]    duty,
    output logic [PWM_W-1:0]     pwm_duty,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUTY_W-1:0]    cfg_data
);

    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_pop;
    logic             res_push;
    res_t             res;
    res_t             head;
    logic [RQ_CW-1:0] res_count;

    lcfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .action    (action),
        .connected (connected),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    lcfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res),
        .res_count (res_count)
    );

    lcfe_res_queue u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .pop     (pop),
        .empty   (empty),
        .rd_data (head),
        .count   (res_count)
    );

    assign duty     = head.duty;
    assign pwm_duty = head.pwm_duty;
    assign last     = head.last;

endmodule
